// ===== src/slpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the status LED pattern generator.
package slpg_pkg;

  localparam int TIME_BITS = 32;

  localparam int LEVEL_W = 8;
  localparam int KIND_W  = 2;
  localparam int MODE_W  = 3;

  localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd20;

  localparam int FLASH_MS      = 80;
  localparam int BOOT_SLOT     = 100;
  localparam int LINK_PERIOD   = 1500;
  localparam int LINK_ON       = 300;
  localparam int BACKEND_SLOT  = 200;
  localparam int BACKEND_SLOTS = 10;
  localparam int ERROR_SLOT    = 150;
  localparam int ERROR_SLOTS   = 20;

  localparam int BOOT_SUB_W = $clog2(BOOT_SLOT);
  localparam int LINK_W     = $clog2(LINK_PERIOD);
  localparam int BK_SUB_W   = $clog2(BACKEND_SLOT);
  localparam int BK_SLOT_W  = $clog2(BACKEND_SLOTS);
  localparam int ERR_SUB_W  = $clog2(ERROR_SLOT);
  localparam int ERR_SLOT_W = $clog2(ERROR_SLOTS);

  localparam logic [ERROR_SLOTS-1:0] ERROR_ON_MASK = 20'h151D5;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_FLASH = 2'd1,
    KIND_MODE  = 2'd2
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_BOOT       = 3'd0,
    MODE_NO_LINK    = 3'd1,
    MODE_NO_BACKEND = 3'd2,
    MODE_ONLINE     = 3'd3,
    MODE_ERROR      = 3'd4
  } mode_t;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [LEVEL_W-1:0]   level_t;

endpackage

// ===== src/slpg_intf.sv =====
`timescale 1ns / 1ps
// Handshake channel interfaces of the status LED pattern generator.
interface slpg_item_if;
  logic                        valid;
  logic                        ready;
  logic [slpg_pkg::KIND_W-1:0] kind;
  logic [slpg_pkg::MODE_W-1:0] mode;
  modport source (output valid, output kind, output mode, input ready);
  modport sink (input valid, input kind, input mode, output ready);
endinterface

interface slpg_cfg_if;
  logic                  valid;
  logic                  ready;
  slpg_pkg::level_t      data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slpg_result_if;
  logic             valid;
  logic             ready;
  slpg_pkg::level_t red;
  slpg_pkg::level_t green;
  slpg_pkg::level_t blue;
  logic             lit;
  modport source (output valid, output red, output green, output blue, output lit,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input lit,
                output ready);
endinterface

// ===== src/status_led_pattern_generator.sv =====
`timescale 1ns / 1ps
// Status LED pattern generator: top level with counters, mode, flash timer and colour.
// Latency: a result is valid in the cycle after its item's transfer.
// Throughput: one item per cycle; the input is taken while the result register
// is empty or being emptied, so a stalled result holds back the next item.
// Reset (synchronous, active high) clears the counters, the flash and the colour,
// selects boot mode and sets the brightness to 20. The configuration port never stalls.
module status_led_pattern_generator (
  input logic clk,
  input logic rst,
  slpg_item_if.sink item,
  slpg_cfg_if.sink cfg,
  slpg_result_if.source result
);

  slpg_pkg::level_t brightness;
  slpg_pkg::time_t  ms_count, ms_count_next;
  slpg_pkg::time_t  flash_begin, flash_begin_next;
  logic             flash_on, flash_on_next;
  logic [slpg_pkg::MODE_W-1:0] led_mode, led_mode_next;
  slpg_pkg::level_t red, red_next, green, green_next, blue, blue_next;
  logic             lit, lit_next;
  logic             res_valid;

  logic [slpg_pkg::BOOT_SUB_W-1:0] boot_sub, boot_sub_next;
  logic                            boot_odd, boot_odd_next;
  logic [slpg_pkg::LINK_W-1:0]     link_pos, link_pos_next;
  logic [slpg_pkg::BK_SUB_W-1:0]   bk_sub, bk_sub_next;
  logic [slpg_pkg::BK_SLOT_W-1:0]  bk_slot, bk_slot_next;
  logic [slpg_pkg::ERR_SUB_W-1:0]  err_sub, err_sub_next;
  logic [slpg_pkg::ERR_SLOT_W-1:0] err_slot, err_slot_next;

  logic            accept;
  logic            wrap;
  slpg_pkg::time_t age;
  logic            pattern_on;

  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign result.valid = res_valid;
  assign result.red   = red;
  assign result.green = green;
  assign result.blue  = blue;
  assign result.lit   = lit;

  // The phase counters follow the millisecond counter and restart with it on wrap.
  always_comb begin
    wrap = &ms_count;
    boot_sub_next = '0;
    boot_odd_next = 1'b0;
    link_pos_next = '0;
    bk_sub_next   = '0;
    bk_slot_next  = '0;
    err_sub_next  = '0;
    err_slot_next = '0;
    if (!wrap) begin
      boot_odd_next = boot_odd;
      if (boot_sub == slpg_pkg::BOOT_SUB_W'(slpg_pkg::BOOT_SLOT - 1)) begin
        boot_odd_next = !boot_odd;
      end else begin
        boot_sub_next = boot_sub + 1'b1;
      end
      if (link_pos != slpg_pkg::LINK_W'(slpg_pkg::LINK_PERIOD - 1)) begin
        link_pos_next = link_pos + 1'b1;
      end
      bk_slot_next = bk_slot;
      if (bk_sub == slpg_pkg::BK_SUB_W'(slpg_pkg::BACKEND_SLOT - 1)) begin
        if (bk_slot != slpg_pkg::BK_SLOT_W'(slpg_pkg::BACKEND_SLOTS - 1)) begin
          bk_slot_next = bk_slot + 1'b1;
        end else begin
          bk_slot_next = '0;
        end
      end else begin
        bk_sub_next = bk_sub + 1'b1;
      end
      err_slot_next = err_slot;
      if (err_sub == slpg_pkg::ERR_SUB_W'(slpg_pkg::ERROR_SLOT - 1)) begin
        if (err_slot != slpg_pkg::ERR_SLOT_W'(slpg_pkg::ERROR_SLOTS - 1)) begin
          err_slot_next = err_slot + 1'b1;
        end else begin
          err_slot_next = '0;
        end
      end else begin
        err_sub_next = err_sub + 1'b1;
      end
    end
  end

  always_comb begin
    ms_count_next    = ms_count;
    flash_begin_next = flash_begin;
    flash_on_next    = flash_on;
    led_mode_next    = led_mode;
    red_next         = red;
    green_next       = green;
    blue_next        = blue;
    age              = ms_count + 1'b1 - flash_begin;
    pattern_on       = 1'b0;
    case (item.kind)
      slpg_pkg::KIND_TICK: begin
        ms_count_next = ms_count + 1'b1;
        if (flash_on && age > slpg_pkg::TIME_BITS'(slpg_pkg::FLASH_MS)) begin
          flash_on_next = 1'b0;
        end
        if (!flash_on_next) begin
          case (led_mode)
            slpg_pkg::MODE_BOOT: begin
              pattern_on = !boot_odd_next;
              red_next   = '0;
              green_next = '0;
              blue_next  = pattern_on ? brightness : '0;
            end
            slpg_pkg::MODE_NO_LINK: begin
              pattern_on = link_pos_next < slpg_pkg::LINK_W'(slpg_pkg::LINK_ON);
              red_next   = pattern_on ? brightness : '0;
              green_next = pattern_on ? (brightness >> 1) : '0;
              blue_next  = '0;
            end
            slpg_pkg::MODE_NO_BACKEND: begin
              pattern_on = (bk_slot_next == slpg_pkg::BK_SLOT_W'(0))
                        || (bk_slot_next == slpg_pkg::BK_SLOT_W'(2));
              red_next   = pattern_on ? brightness : '0;
              green_next = pattern_on ? (brightness >> 2) : '0;
              blue_next  = '0;
            end
            slpg_pkg::MODE_ONLINE: begin
              red_next   = '0;
              green_next = brightness;
              blue_next  = '0;
            end
            slpg_pkg::MODE_ERROR: begin
              pattern_on = slpg_pkg::ERROR_ON_MASK[err_slot_next];
              red_next   = pattern_on ? brightness : '0;
              green_next = '0;
              blue_next  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      slpg_pkg::KIND_FLASH: begin
        flash_on_next    = 1'b1;
        flash_begin_next = ms_count;
        red_next         = brightness;
        green_next       = brightness;
        blue_next        = brightness;
      end
      slpg_pkg::KIND_MODE: begin
        led_mode_next = item.mode;
      end
      default: begin
      end
    endcase
    lit_next = (red_next != '0) || (green_next != '0) || (blue_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= slpg_pkg::BRIGHT_RESET;
      ms_count    <= '0;
      flash_begin <= '0;
      flash_on    <= 1'b0;
      led_mode    <= slpg_pkg::MODE_BOOT;
      red         <= '0;
      green       <= '0;
      blue        <= '0;
      lit         <= 1'b0;
      res_valid   <= 1'b0;
      boot_sub    <= '0;
      boot_odd    <= 1'b0;
      link_pos    <= '0;
      bk_sub      <= '0;
      bk_slot     <= '0;
      err_sub     <= '0;
      err_slot    <= '0;
    end else begin
      if (cfg.valid) begin
        brightness <= cfg.data;
      end
      if (accept) begin
        ms_count    <= ms_count_next;
        flash_begin <= flash_begin_next;
        flash_on    <= flash_on_next;
        led_mode    <= led_mode_next;
        red         <= red_next;
        green       <= green_next;
        blue        <= blue_next;
        lit         <= lit_next;
        res_valid   <= 1'b1;
        if (item.kind == slpg_pkg::KIND_TICK) begin
          boot_sub <= boot_sub_next;
          boot_odd <= boot_odd_next;
          link_pos <= link_pos_next;
          bk_sub   <= bk_sub_next;
          bk_slot  <= bk_slot_next;
          err_sub  <= err_sub_next;
          err_slot <= err_slot_next;
        end
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/slpg_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the status LED pattern generator, bound to the top level.
module slpg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic [slpg_pkg::KIND_W-1:0] item_kind,
  input logic                        result_valid,
  input logic                        result_ready,
  input slpg_pkg::level_t            result_red,
  input slpg_pkg::level_t            result_green,
  input slpg_pkg::level_t            result_blue,
  input logic                        result_lit
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted item produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("input taken while the result is stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_red)
      && $stable(result_green) && $stable(result_blue) && $stable(result_lit))
    else $error("stalled result changed");

  a_flash_white: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_kind == slpg_pkg::KIND_FLASH
      |=> result_red == result_green && result_green == result_blue)
    else $error("flash result is not white");

  a_lit_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_lit
      == (result_red != '0 || result_green != '0 || result_blue != '0))
    else $error("lit does not match the colour");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_kind    (item.kind),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_red   (result.red),
  .result_green (result.green),
  .result_blue  (result.blue),
  .result_lit   (result.lit)
);

// ===== bench/status_led_pattern_generator_tb.sv =====
`timescale 1ns / 1ps
// Testbench of the status LED pattern generator: a directed table, then random bursts.
module status_led_pattern_generator_tb;

  localparam logic [slpg_pkg::KIND_W-1:0] KIND_SPARE     = 2'd3;
  localparam logic [slpg_pkg::MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [slpg_pkg::MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [slpg_pkg::MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    slpg_pkg::level_t red;
    slpg_pkg::level_t green;
    slpg_pkg::level_t blue;
    logic             lit;
  } color_t;

  typedef struct {
    logic [slpg_pkg::KIND_W-1:0] kind;
    logic [slpg_pkg::MODE_W-1:0] mode;
    bit                          typed;
    color_t                      want;
  } stim_row_t;

  localparam color_t DARK  = '{8'd0, 8'd0, 8'd0, 1'b0};
  localparam color_t BLUE  = '{8'd0, 8'd0, slpg_pkg::BRIGHT_RESET, 1'b1};
  localparam color_t WHITE = '{slpg_pkg::BRIGHT_RESET, slpg_pkg::BRIGHT_RESET,
                               slpg_pkg::BRIGHT_RESET, 1'b1};

  stim_row_t directed_rows [16] = '{
    '{slpg_pkg::KIND_TICK,  slpg_pkg::MODE_BOOT,       1'b1, BLUE},
    '{KIND_SPARE,           MODE_SPARE_HI,             1'b1, BLUE},
    '{slpg_pkg::KIND_FLASH, slpg_pkg::MODE_BOOT,       1'b1, WHITE},
    '{slpg_pkg::KIND_MODE,  slpg_pkg::MODE_ONLINE,     1'b1, WHITE},
    '{slpg_pkg::KIND_TICK,  slpg_pkg::MODE_BOOT,       1'b1, WHITE},
    '{slpg_pkg::KIND_MODE,  slpg_pkg::MODE_ERROR,      1'b1, WHITE},
    '{slpg_pkg::KIND_MODE,  MODE_SPARE_HI,             1'b1, WHITE},
    '{slpg_pkg::KIND_TICK,  MODE_SPARE_HI,             1'b1, WHITE},
    '{slpg_pkg::KIND_MODE,  MODE_SPARE_LO,             1'b0, DARK},
    '{slpg_pkg::KIND_MODE,  MODE_SPARE_MID,            1'b0, DARK},
    '{slpg_pkg::KIND_MODE,  slpg_pkg::MODE_NO_LINK,    1'b0, DARK},
    '{slpg_pkg::KIND_MODE,  slpg_pkg::MODE_NO_BACKEND, 1'b0, DARK},
    '{slpg_pkg::KIND_FLASH, slpg_pkg::MODE_ERROR,      1'b1, WHITE},
    '{KIND_SPARE,           slpg_pkg::MODE_BOOT,       1'b0, DARK},
    '{slpg_pkg::KIND_MODE,  slpg_pkg::MODE_BOOT,       1'b0, DARK},
    '{slpg_pkg::KIND_TICK,  slpg_pkg::MODE_ONLINE,     1'b0, DARK}
  };

  logic clk;
  logic rst;
  bit   hold_req;
  int   errors;
  int   cycle_count;

  slpg_pkg::time_t             led_ms;
  slpg_pkg::time_t             flash_start;
  bit                          flash_showing;
  logic [slpg_pkg::MODE_W-1:0] led_mode_now;
  color_t                      shown;
  slpg_pkg::level_t            bright;

  color_t due_colors[$];

  slpg_item_if   item_ch ();
  slpg_cfg_if    cfg_ch ();
  slpg_result_if res_ch ();

  status_led_pattern_generator DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  function automatic color_t make_color(slpg_pkg::level_t r, slpg_pkg::level_t g,
                                        slpg_pkg::level_t b);
    color_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    c.lit   = |{r, g, b};
    return c;
  endfunction

  function automatic color_t pattern_color(slpg_pkg::time_t t,
                                           logic [slpg_pkg::MODE_W-1:0] m,
                                           slpg_pkg::level_t lvl, color_t held);
    color_t      c;
    int unsigned ph;
    c = DARK;
    case (m)
      slpg_pkg::MODE_BOOT: begin
        if (((t / slpg_pkg::BOOT_SLOT) & 1) == 0) c = make_color(8'd0, 8'd0, lvl);
      end
      slpg_pkg::MODE_NO_LINK: begin
        if ((t % slpg_pkg::LINK_PERIOD) < slpg_pkg::LINK_ON)
          c = make_color(lvl, lvl >> 1, 8'd0);
      end
      slpg_pkg::MODE_NO_BACKEND: begin
        ph = (t / slpg_pkg::BACKEND_SLOT) % slpg_pkg::BACKEND_SLOTS;
        if (ph == 0 || ph == 2) c = make_color(lvl, lvl >> 2, 8'd0);
      end
      slpg_pkg::MODE_ONLINE: c = make_color(8'd0, lvl, 8'd0);
      slpg_pkg::MODE_ERROR: begin
        ph = (t / slpg_pkg::ERROR_SLOT) % slpg_pkg::ERROR_SLOTS;
        if (slpg_pkg::ERROR_ON_MASK[ph]) c = make_color(lvl, 8'd0, 8'd0);
      end
      default: c = held;
    endcase
    return c;
  endfunction

  function automatic color_t advance_led(logic [slpg_pkg::KIND_W-1:0] k,
                                         logic [slpg_pkg::MODE_W-1:0] m);
    case (k)
      slpg_pkg::KIND_TICK: begin
        led_ms = led_ms + 1;
        if (flash_showing
            && (slpg_pkg::time_t'(led_ms - flash_start) > slpg_pkg::FLASH_MS))
          flash_showing = 1'b0;
        if (!flash_showing) shown = pattern_color(led_ms, led_mode_now, bright, shown);
      end
      slpg_pkg::KIND_FLASH: begin
        flash_showing = 1'b1;
        flash_start   = led_ms;
        shown         = make_color(bright, bright, bright);
      end
      slpg_pkg::KIND_MODE: led_mode_now = m;
      default: ;
    endcase
    return shown;
  endfunction

  task automatic send_item(logic [slpg_pkg::KIND_W-1:0] k, logic [slpg_pkg::MODE_W-1:0] m,
                           bit typed, color_t want);
    color_t predicted;
    item_ch.valid <= 1'b1;
    item_ch.kind  <= k;
    item_ch.mode  <= m;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    predicted = advance_led(k, m);
    due_colors.push_back(typed ? want : predicted);
  endtask

  task automatic pause_items(int cycles);
    item_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic set_brightness(slpg_pkg::level_t value);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_colors.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    bright = value;
  endtask

  task automatic run_random(int count);
    int                          burst_left;
    int                          pick;
    logic [slpg_pkg::KIND_W-1:0] k;
    logic [slpg_pkg::MODE_W-1:0] m;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) pause_items($urandom_range(1, 8));
      end
      burst_left--;
      pick = $urandom_range(0, 999);
      m    = slpg_pkg::MODE_W'($urandom_range(0, 7));
      if (pick < 975) begin
        k = slpg_pkg::KIND_TICK;
      end else if (pick < 982) begin
        k = slpg_pkg::KIND_FLASH;
      end else if (pick < 990) begin
        k = slpg_pkg::KIND_MODE;
        if ($urandom_range(0, 9) < 8)
          m = slpg_pkg::MODE_W'($urandom_range(slpg_pkg::MODE_BOOT, slpg_pkg::MODE_ERROR));
        else
          m = slpg_pkg::MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end else begin
        k = KIND_SPARE;
      end
      send_item(k, m, 1'b0, DARK);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** status_led_pattern_generator: FAILED **");
      $finish;
    end
  end

  initial begin
    int seg_len;
    int stall_pct;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      seg_len = $urandom_range(20, 200);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
      repeat (seg_len) begin
        @(posedge clk);
        if (hold_req) begin
          res_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_colour
    color_t due;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (due_colors.size() == 0) begin
        $display("%0t: colour with none expected: r=%0d g=%0d b=%0d lit=%0b", $time,
                 res_ch.red, res_ch.green, res_ch.blue, res_ch.lit);
        errors++;
      end else begin
        due = due_colors.pop_front();
        if (res_ch.red !== due.red) begin
          $display("%0t: red expected %0d, actual %0d", $time, due.red, res_ch.red);
          errors++;
        end
        if (res_ch.green !== due.green) begin
          $display("%0t: green expected %0d, actual %0d", $time, due.green, res_ch.green);
          errors++;
        end
        if (res_ch.blue !== due.blue) begin
          $display("%0t: blue expected %0d, actual %0d", $time, due.blue, res_ch.blue);
          errors++;
        end
        if (res_ch.lit !== due.lit) begin
          $display("%0t: lit expected %0b, actual %0b", $time, due.lit, res_ch.lit);
          errors++;
        end
      end
    end
  end

  initial begin
    errors        = 0;
    cycle_count   = 0;
    hold_req      = 1'b0;
    led_ms        = '0;
    flash_start   = '0;
    flash_showing = 1'b0;
    led_mode_now  = slpg_pkg::MODE_BOOT;
    shown         = DARK;
    bright        = slpg_pkg::BRIGHT_RESET;
    rst           <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.kind  <= slpg_pkg::KIND_TICK;
    item_ch.mode  <= slpg_pkg::MODE_BOOT;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].mode, directed_rows[i].typed,
                directed_rows[i].want);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: set_brightness(8'hFF);
        2: set_brightness(8'h00);
        3: set_brightness(8'd3);
        4: set_brightness(slpg_pkg::level_t'($urandom_range(1, 254)));
        default: ;
      endcase
      // The long receiver hold-off lets the result register fill and stall the input.
      if (p == 1) hold_req = 1'b1;
      run_random(PHASE_ITEMS);
    end

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_colors.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** status_led_pattern_generator: PASSED **");
    end else begin
      $display("** status_led_pattern_generator: FAILED **");
    end
    $finish;
  end

endmodule
